FILE: hw/rtl/utpe_pkg.sv
// Shared types, constants and protocol codes for the UDP transport stream PCR extractor.
package utpe_pkg;

    // Default frame length limit, handed down from the top level
    localparam int MAX_FRAME_BYTES_DEF = 16384;

    // Port widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 144;
    localparam int TIME_W      = 63;
    localparam int PCR_RAW_W   = 48;
    localparam int PCR_US_W    = 37;

    // Frame parser states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_IPHDR   = 2'd1;
    localparam logic [1:0] ST_UDPHDR  = 2'd2;
    localparam logic [1:0] ST_PAYLOAD = 2'd3;

    // Header byte positions and expected values
    localparam logic [15:0] POS_TYPE_HI  = 16'd12;
    localparam logic [15:0] POS_TYPE_LO  = 16'd13;
    localparam logic [15:0] POS_IP_VIHL  = 16'd14;
    localparam logic [15:0] POS_IP_PROTO = 16'd23;
    localparam logic [7:0]  ETH_TYPE_HI  = 8'h08;
    localparam logic [7:0]  ETH_TYPE_LO  = 8'h00;
    localparam logic [3:0]  IP_VERSION4  = 4'h4;
    localparam logic [3:0]  IP_IHL_MIN   = 4'd5;
    localparam logic [7:0]  IP_PROTO_UDP = 8'h11;

    // UDP header byte positions relative to its start
    localparam logic [15:0] UDP_DPORT_HI = 16'd2;
    localparam logic [15:0] UDP_DPORT_LO = 16'd3;
    localparam logic [15:0] UDP_HDR_LAST = 16'd7;

    // Transport stream slot layout
    localparam logic [7:0] SLOT_LAST      = 8'd187;
    localparam logic [7:0] SYNC_BYTE      = 8'h47;
    localparam logic [7:0] SO_HDR_HI      = 8'd1;
    localparam logic [7:0] SO_HDR_LO      = 8'd2;
    localparam logic [7:0] SO_AF_CTRL     = 8'd3;
    localparam logic [7:0] SO_AF_LEN      = 8'd4;
    localparam logic [7:0] SO_AF_FLAGS    = 8'd5;
    localparam logic [7:0] SO_PCR_LAST    = 8'd11;
    localparam int         AF_PRESENT_BIT = 5;
    localparam int         PCR_FLAG_BIT   = 4;

    // PCR to microseconds: (base*300 + ext) / 27, split into two exact reciprocal steps
    localparam int          X_W          = 42;
    localparam int          XL_W         = 21;
    localparam int          XH_W         = 21;
    localparam int          QH_W         = 17;
    localparam int          Q2_W         = 21;
    localparam int          Y_W          = 26;
    localparam int          P1_W         = 43;
    localparam int          P2_W         = 53;
    localparam int          REM_W        = 5;
    localparam logic [8:0]  PCR_MULT     = 9'd300;
    localparam logic [4:0]  PCR_DIV      = 5'd27;
    localparam logic [21:0] RECIP_HI     = 22'd2485514;
    localparam int          RECIP_SH_HI  = 26;
    localparam logic [26:0] RECIP_LO     = 27'd79536432;
    localparam int          RECIP_SH_LO  = 31;

    // Record fields other than the PCR value
    typedef struct packed {
        logic [15:0]       dest_port;
        logic [12:0]       packet_id;
        logic              transport_error;
        logic              pcr_valid;
        logic [TIME_W-1:0] packet_time_us;
        logic [8:0]        slot_number;
    } t_rec_meta;

endpackage

FILE: hw/rtl/utpe_parser.sv
// Byte-wise frame parser: header checks, UDP port capture and slot walk with record build.
module utpe_parser
    import utpe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    input  logic                 i_end,
    input  logic [TIME_W-1:0]    i_time,
    output logic                 o_rec_vld,
    input  logic                 i_rec_ready,
    output t_rec_meta            o_rec,
    output logic [PCR_RAW_W-1:0] o_rec_pcr
);

    localparam int               OFF_W    = $clog2(MAX_FRAME_BYTES);
    localparam logic [OFF_W-1:0] LAST_POS = OFF_W'(MAX_FRAME_BYTES - 1);

    logic [1:0]           r_hs,    n_hs;
    logic [OFF_W-1:0]     r_off,   n_off;
    logic [5:0]           r_ihb,   n_ihb;
    logic [15:0]          r_port,  n_port;
    logic [7:0]           r_soff,  n_soff;
    logic [8:0]           r_scnt,  n_scnt;
    logic [16:0]          r_shb,   n_shb;
    logic [PCR_RAW_W-1:0] r_pcr,   n_pcr;
    logic [TIME_W-1:0]    r_ftime, n_ftime;
    logic                 r_rec_vld;
    t_rec_meta            r_rec,   n_rec;
    logic [PCR_RAW_W-1:0] r_rec_pcr;

    logic acc;
    logic active;
    logic last;
    logic emit;

    assign o_ready = !r_rec_vld || i_rec_ready;
    assign acc     = i_valid && o_ready;

    // Next state for one frame byte
    always_comb begin
        logic [1:0]           cur_hs;
        logic [OFF_W-1:0]     pos;
        logic [15:0]          pos_w;
        logic [15:0]          upos;
        logic [5:0]           cur_ihb;
        logic [15:0]          cur_port;
        logic [7:0]           cur_soff;
        logic [8:0]           cur_scnt;
        logic [16:0]          cur_shb;
        logic [PCR_RAW_W-1:0] cur_pcr;
        logic [TIME_W-1:0]    cur_ftime;
        logic [16:0]          hdr;
        logic                 reject;
        logic                 emit_pcr;

        cur_hs    = i_start ? ST_IPHDR : r_hs;
        pos       = i_start ? '0 : r_off;
        cur_ihb   = i_start ? '0 : r_ihb;
        cur_port  = i_start ? '0 : r_port;
        cur_soff  = i_start ? '0 : r_soff;
        cur_scnt  = i_start ? '0 : r_scnt;
        cur_shb   = i_start ? '0 : r_shb;
        cur_pcr   = i_start ? '0 : r_pcr;
        cur_ftime = i_start ? i_time : r_ftime;

        active   = i_start || (r_hs != ST_IDLE);
        last     = i_end || (pos >= LAST_POS);
        pos_w    = 16'(pos);
        upos     = pos_w - POS_IP_VIHL - 16'(cur_ihb);
        reject   = 1'b0;
        emit     = 1'b0;
        emit_pcr = 1'b0;
        hdr      = cur_shb;

        n_hs    = cur_hs;
        n_off   = r_off;
        n_ihb   = cur_ihb;
        n_port  = cur_port;
        n_soff  = cur_soff;
        n_scnt  = cur_scnt;
        n_shb   = cur_shb;
        n_pcr   = cur_pcr;
        n_ftime = cur_ftime;

        unique case (cur_hs)
            ST_IPHDR: begin
                // Check ethertype, IP version/IHL and protocol
                reject = ((pos_w == POS_TYPE_HI) && (i_byte != ETH_TYPE_HI)) ||
                         ((pos_w == POS_TYPE_LO) && (i_byte != ETH_TYPE_LO)) ||
                         ((pos_w == POS_IP_VIHL) && ((i_byte[7:4] != IP_VERSION4) ||
                                                     (i_byte[3:0] < IP_IHL_MIN))) ||
                         ((pos_w == POS_IP_PROTO) && (i_byte != IP_PROTO_UDP));
                if ((pos_w == POS_IP_VIHL) && !reject) begin
                    n_ihb = {i_byte[3:0], 2'b00};
                end
                if (reject) begin
                    n_hs = ST_IDLE;
                end else if ((pos_w > POS_IP_VIHL) &&
                             (pos_w == POS_TYPE_LO + 16'(cur_ihb))) begin
                    n_hs = ST_UDPHDR;
                end
            end
            ST_UDPHDR: begin
                // Capture destination port, enter payload after the header
                if (upos == UDP_DPORT_HI) begin
                    n_port = {i_byte, 8'h00};
                end else if (upos == UDP_DPORT_LO) begin
                    n_port = cur_port | 16'(i_byte);
                end else if (upos == UDP_HDR_LAST) begin
                    n_hs   = ST_PAYLOAD;
                    n_soff = '0;
                    n_scnt = '0;
                    n_shb  = '0;
                end
            end
            ST_PAYLOAD: begin
                // Walk the slot: sync, header bytes, adaptation flags, PCR bytes
                if (cur_soff == '0) begin
                    n_shb = (i_byte == SYNC_BYTE) ? {1'b1, 16'h0000} : '0;
                    n_pcr = '0;
                end else if (cur_shb[16]) begin
                    if (cur_soff == SO_HDR_HI) begin
                        n_shb = cur_shb | {1'b0, i_byte, 8'h00};
                    end else if (cur_soff == SO_HDR_LO) begin
                        n_shb = cur_shb | {9'b0, i_byte};
                        hdr   = n_shb;
                        emit  = n_shb[15] || last;
                    end else if (cur_soff == SO_AF_CTRL) begin
                        emit = !i_byte[AF_PRESENT_BIT] || last;
                    end else if (cur_soff == SO_AF_LEN) begin
                        emit = last;
                    end else if (cur_soff == SO_AF_FLAGS) begin
                        emit = !i_byte[PCR_FLAG_BIT] || last;
                    end else if (cur_soff <= SO_PCR_LAST) begin
                        n_pcr    = {cur_pcr[PCR_RAW_W-9:0], i_byte};
                        emit_pcr = (cur_soff == SO_PCR_LAST);
                        emit     = emit_pcr || last;
                    end
                end
                if (emit) begin
                    n_shb = '0;
                end
                // Advance slot position
                if (cur_soff == SLOT_LAST) begin
                    n_soff = '0;
                    n_scnt = cur_scnt + 9'd1;
                end else begin
                    n_soff = cur_soff + 8'd1;
                end
            end
            default: begin
            end
        endcase

        // Close the frame on its last byte, else step the offset
        if (active && last) begin
            n_hs  = ST_IDLE;
            n_shb = '0;
        end else if (active) begin
            n_off = pos + OFF_W'(1);
        end

        n_rec.dest_port       = cur_port;
        n_rec.packet_id       = hdr[12:0];
        n_rec.transport_error = hdr[15];
        n_rec.pcr_valid       = emit_pcr;
        n_rec.packet_time_us  = cur_ftime;
        n_rec.slot_number     = cur_scnt;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs      <= ST_IDLE;
            r_rec_vld <= 1'b0;
        end else begin
            if (acc && active) begin
                r_hs <= n_hs;
            end
            if (o_ready) begin
                r_rec_vld <= acc && active && emit;
            end
        end
    end

    // Frame context and record registers
    always_ff @(posedge i_clk) begin
        if (acc && active) begin
            r_off   <= n_off;
            r_ihb   <= n_ihb;
            r_port  <= n_port;
            r_soff  <= n_soff;
            r_scnt  <= n_scnt;
            r_shb   <= n_shb;
            r_pcr   <= n_pcr;
            r_ftime <= n_ftime;
        end
        if (acc && active && emit) begin
            r_rec     <= n_rec;
            r_rec_pcr <= n_pcr;
        end
    end

    assign o_rec_vld = r_rec_vld;
    assign o_rec     = r_rec;
    assign o_rec_pcr = r_rec_pcr;

    // A frame's last byte always returns the parser to idle
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && active && last) |=> (r_hs == ST_IDLE))
        else $error("parser not idle after last frame byte");

    // A PCR is only reported for slots without transport error
    a_pcr_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_vld && r_rec.pcr_valid) |-> !r_rec.transport_error)
        else $error("PCR record with transport error set");

endmodule

FILE: hw/rtl/utpe_pcr_conv.sv
// Pipelined PCR to microsecond conversion, (base*300+ext)/27 by exact reciprocal steps.
module utpe_pcr_conv
    import utpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rec_vld,
    output logic                 o_rec_ready,
    input  t_rec_meta            i_rec,
    input  logic [PCR_RAW_W-1:0] i_rec_pcr,
    output logic                 o_vld,
    input  logic                 i_ready,
    output t_rec_meta            o_meta,
    output logic [PCR_US_W-1:0]  o_pcr_us
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    t_rec_meta       r_meta [NSTG];

    logic [X_W-1:0]      r_x;
    logic [P1_W-1:0]     r_p1;
    logic [XH_W-1:0]     r_b_xh;
    logic [XL_W-1:0]     r_b_xl;
    logic [QH_W-1:0]     r_c_qh;
    logic [Y_W-1:0]      r_y;
    logic [QH_W-1:0]     r_d_qh;
    logic [P2_W-1:0]     r_p2;
    logic [PCR_US_W-1:0] r_us;

    logic [X_W-1:0]  x_a;
    logic [QH_W-1:0] qh_c;
    logic [XH_W-1:0] rem_c;
    logic [Q2_W-1:0] q2_e;

    // Stage advances when empty or when the next one advances
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_rec_ready = en[0];

    // Stage arithmetic
    assign x_a   = i_rec.pcr_valid ?
                   (X_W'(i_rec_pcr[PCR_RAW_W-1:15]) * X_W'(PCR_MULT) + X_W'(i_rec_pcr[8:0])) :
                   '0;
    assign qh_c  = r_p1[RECIP_SH_HI +: QH_W];
    assign rem_c = r_b_xh - XH_W'(qh_c) * XH_W'(PCR_DIV);
    assign q2_e  = r_p2[RECIP_SH_LO +: Q2_W];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_rec_vld;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Data path: scale, high-part divide, remainder merge, low-part divide, join
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_meta[0] <= i_rec;
            r_x       <= x_a;
        end
        if (en[1]) begin
            r_meta[1] <= r_meta[0];
            r_p1      <= P1_W'(r_x[X_W-1:XL_W]) * P1_W'(RECIP_HI);
            r_b_xh    <= r_x[X_W-1:XL_W];
            r_b_xl    <= r_x[XL_W-1:0];
        end
        if (en[2]) begin
            r_meta[2] <= r_meta[1];
            r_c_qh    <= qh_c;
            r_y       <= {rem_c[REM_W-1:0], r_b_xl};
        end
        if (en[3]) begin
            r_meta[3] <= r_meta[2];
            r_d_qh    <= r_c_qh;
            r_p2      <= P2_W'(r_y) * P2_W'(RECIP_LO);
        end
        if (en[4]) begin
            r_meta[4] <= r_meta[3];
            r_us      <= PCR_US_W'({r_d_qh, q2_e});
        end
    end

    assign o_vld    = r_vld[NSTG-1];
    assign o_meta   = r_meta[NSTG-1];
    assign o_pcr_us = r_us;

    // Records without a PCR carry a zero time
    a_zero_us: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !r_meta[NSTG-1].pcr_valid) |-> (r_us == '0))
        else $error("nonzero PCR time on record without PCR");

    // A record in the last inner stage reaches the output when it may move
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-2] && en[NSTG-1]) |=> r_vld[NSTG-1])
        else $error("record lost between conversion stages");

endmodule

FILE: hw/rtl/udp_ts_pcr_extractor.sv
// Top level of the UDP transport stream PCR extractor: stream ports, parser and PCR conversion.
//
//  Channel   Direction  Transfers             Payload
//  s_axis    in         one frame byte        tdata: byte, arrival time; tuser: start; tlast: end
//  m_axis    out        one slot record       tdata: port, PID, error, PCR flag, PCR us, time, slot
//
//  One frame byte is taken every cycle unless the record path stalls; the parser decides
//  each byte combinationally. A record leaves through the parser register and then the five
//  conversion stages, set by the two reciprocal multiplies of the divide by 27.
//  Reset is synchronous, active low, and clears the parser state and all stage valid bits.
//  A stalled output stops only the stages behind it that are full; empty stages keep
//  taking records, so input bytes flow on while a finished record waits.
module udp_ts_pcr_extractor
    import utpe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] frame_byte, [70:8] arrival_us
    input  logic                   i_s_axis_tuser,  // [0] frame_start
    input  logic                   i_s_axis_tlast,  // frame_end
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [15:0] dest_port, [28:16] packet_id, [29] transport_error, [30] pcr_valid,
    // [67:31] pcr_us, [130:68] packet_time_us, [139:131] slot_number
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic                 rec_vld;
    logic                 rec_ready;
    t_rec_meta            rec;
    logic [PCR_RAW_W-1:0] rec_pcr;
    t_rec_meta            out_meta;
    logic [PCR_US_W-1:0]  out_us;

    // Parse frames into slot records
    utpe_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata[7:0]),
        .i_start     (i_s_axis_tuser),
        .i_end       (i_s_axis_tlast),
        .i_time      (i_s_axis_tdata[8 +: TIME_W]),
        .o_rec_vld   (rec_vld),
        .i_rec_ready (rec_ready),
        .o_rec       (rec),
        .o_rec_pcr   (rec_pcr)
    );

    // Convert PCR to microseconds
    utpe_pcr_conv u_pcr_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_vld   (rec_vld),
        .o_rec_ready (rec_ready),
        .i_rec       (rec),
        .i_rec_pcr   (rec_pcr),
        .o_vld       (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_meta      (out_meta),
        .o_pcr_us    (out_us)
    );

    // Pack the record transaction
    assign o_m_axis_tdata = {4'b0000,
                             out_meta.slot_number,
                             out_meta.packet_time_us,
                             out_us,
                             out_meta.pcr_valid,
                             out_meta.transport_error,
                             out_meta.packet_id,
                             out_meta.dest_port};

endmodule
